// ===== sv/mec_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot escape counter.
`default_nettype none
package mec_pkg;

   localparam int COORD_BITS_DEF = 10;
   localparam int FRAC_BITS_DEF  = 26;
   localparam int ITER_BITS_DEF  = 16;

   localparam int ZBITS      = 32;
   localparam int CENTRE_W   = 28;
   localparam int HEIGHT_W   = 29;
   localparam int RES_W      = 11;
   localparam int COUNT_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int SAT_W      = 66;

   localparam logic signed [CENTRE_W-1:0] CENTRE_RE_RST = -28'sd49660559;
   localparam logic signed [CENTRE_W-1:0] CENTRE_IM_RST = 28'sd10066330;
   localparam logic [HEIGHT_W-1:0]        HEIGHT_RST    = 29'd73819750;
   localparam logic [RES_W-1:0]           RES_W_RST     = 11'd640;
   localparam logic [RES_W-1:0]           RES_H_RST     = 11'd480;
   localparam logic [COUNT_W-1:0]         MAX_ITER_RST  = 16'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTRE_RE = 3'd0,
      CSR_CENTRE_IM = 3'd1,
      CSR_HEIGHT    = 3'd2,
      CSR_RES_W     = 3'd3,
      CSR_RES_H     = 3'd4,
      CSR_MAX_ITER  = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic signed [ZBITS-1:0] re;
      logic signed [ZBITS-1:0] im;
   } point_type;

   typedef struct packed {
      logic signed [CENTRE_W-1:0] centre_re;
      logic signed [CENTRE_W-1:0] centre_im;
      logic [HEIGHT_W-1:0]        height;
      logic [RES_W-1:0]           res_w;
      logic [RES_W-1:0]           res_h;
      logic [COUNT_W-1:0]         max_iter;
   } view_type;

   typedef enum logic [2:0] {
      F_IDLE, F_MUL_W, F_DIV_W, F_MUL_X, F_DIV_X, F_MUL_Y, F_DIV_Y, F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE, B_MUL, B_EVAL, B_DONE
   } back_state_type;

   function automatic logic signed [ZBITS-1:0] sat_z(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'({1'b0, {(ZBITS-1){1'b1}}});
      lo = -hi - SAT_W'(1);
      if (v > hi) return {1'b0, {(ZBITS-1){1'b1}}};
      if (v < lo) return {1'b1, {(ZBITS-1){1'b0}}};
      return v[ZBITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/mandelbrot_escape_counter_top.sv =====
// Top level of the Mandelbrot escape counter: CSRs, mapper, queue, iterator.
`default_nettype none
// Channel   Direction  Handshake               Payload
// req       in         req_valid/req_ready     req_pixel_x, req_pixel_y
// rsp       out        rsp_valid/rsp_ready     rsp_escape_count, rsp_hit_limit
// csr       in         csr_valid/csr_ready     csr_index, csr_data
//
// Mapping a pixel: a multiply and a serial division for the width, then for x,
// then for y, and a push into the queue. Iteration: a pop, then per step the
// products and then the compare/update, and a hand-over to the result register.
// The mapper works on the next pixel while the iterator runs; a two-entry
// queue sits between them. Reset is synchronous and restores the view.
// csr_ready is always high; writes to unknown indexes are dropped.
module mandelbrot_escape_counter_top #(
   parameter int COORD_BITS = mec_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = mec_pkg::FRAC_BITS_DEF,
   parameter int ITER_BITS  = mec_pkg::ITER_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire [COORD_BITS-1:0]              req_pixel_x,
   input  wire [COORD_BITS-1:0]              req_pixel_y,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [mec_pkg::COUNT_W-1:0]       rsp_escape_count,
   output logic                              rsp_hit_limit,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [mec_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [mec_pkg::CSR_DATA_W-1:0]     csr_data
);
   // limit is masked to ITER_BITS bits of the iteration counter
   localparam logic [mec_pkg::COUNT_W-1:0] ITER_MASK =
      (ITER_BITS >= mec_pkg::COUNT_W) ? {mec_pkg::COUNT_W{1'b1}}
                                      : mec_pkg::COUNT_W'((64'd1 << ITER_BITS) - 64'd1);

   mec_pkg::view_type  view_ff, view_in;
   mec_pkg::point_type push_data, pop_data;
   logic               push, pop, full, empty;

   assign csr_ready = 1'b1;

   // CSR write decode
   always_comb begin
      view_in = view_ff;
      if (csr_valid) begin
         case (mec_pkg::csr_idx_type'(csr_index))
            mec_pkg::CSR_CENTRE_RE: view_in.centre_re = csr_data[mec_pkg::CENTRE_W-1:0];
            mec_pkg::CSR_CENTRE_IM: view_in.centre_im = csr_data[mec_pkg::CENTRE_W-1:0];
            mec_pkg::CSR_HEIGHT:    view_in.height    = csr_data[mec_pkg::HEIGHT_W-1:0];
            mec_pkg::CSR_RES_W:     view_in.res_w     = csr_data[mec_pkg::RES_W-1:0];
            mec_pkg::CSR_RES_H:     view_in.res_h     = csr_data[mec_pkg::RES_W-1:0];
            mec_pkg::CSR_MAX_ITER:  view_in.max_iter  =
               csr_data[mec_pkg::COUNT_W-1:0] & ITER_MASK;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff.centre_re <= mec_pkg::CENTRE_RE_RST;
         view_ff.centre_im <= mec_pkg::CENTRE_IM_RST;
         view_ff.height    <= mec_pkg::HEIGHT_RST;
         view_ff.res_w     <= mec_pkg::RES_W_RST;
         view_ff.res_h     <= mec_pkg::RES_H_RST;
         view_ff.max_iter  <= mec_pkg::MAX_ITER_RST & ITER_MASK;
      end else begin
         view_ff <= view_in;
      end
   end

   mec_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .view        (view_ff),
      .push        (push),
      .push_data   (push_data),
      .full        (full)
   );

   mec_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   mec_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .pop_data         (pop_data),
      .pop              (pop),
      .max_iter         (view_ff.max_iter),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_escape_count (rsp_escape_count),
      .rsp_hit_limit    (rsp_hit_limit)
   );
endmodule
`default_nettype wire

// ===== sv/mec_fifo.sv =====
// Two-entry queue of plane points between coordinate mapper and iterator.
`default_nettype none
module mec_fifo (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire mec_pkg::point_type push_data,
   output logic                 full,
   input  wire                  pop,
   output mec_pkg::point_type   pop_data,
   output logic                 empty
);
   mec_pkg::point_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ===== sv/mec_front.sv =====
// Front end: accepts a pixel and maps it to a plane point with a serial divider.
`default_nettype none
module mec_front #(
   parameter int COORD_BITS = mec_pkg::COORD_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire [COORD_BITS-1:0]    req_pixel_x,
   input  wire [COORD_BITS-1:0]    req_pixel_y,
   input  wire mec_pkg::view_type  view,
   output logic                    push,
   output mec_pkg::point_type      push_data,
   input  wire                     full
);
   localparam int WW   = mec_pkg::HEIGHT_W + mec_pkg::RES_W;   // width term
   localparam int DIVW = WW + COORD_BITS;                      // dividend
   localparam int SW   = DIVW + 2;                             // coordinate sum
   localparam int CW   = $clog2(DIVW);
   localparam int RW   = mec_pkg::RES_W;

   mec_pkg::front_state_type state_ff, state_in;
   logic [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic [DIVW-1:0]       dvd_ff, dvd_in, qx_ff, qx_in;
   logic [WW-1:0]         wdt_ff, wdt_in;
   logic [RW:0]           rem_ff, rem_in;
   logic [RW-1:0]         dsr_ff, dsr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  div_last;
   logic [RW-1:0]         rw_eff, rh_eff;
   logic [RW:0]           rem_t;
   logic                  q_bit;
   logic signed [SW-1:0]  sum_re, sum_im;

   assign rw_eff   = (view.res_w == '0) ? RW'(1) : view.res_w;
   assign rh_eff   = (view.res_h == '0) ? RW'(1) : view.res_h;
   assign div_last = (cnt_ff == CW'(DIVW - 1));
   assign rem_t    = {rem_ff[RW-1:0], dvd_ff[DIVW-1]};
   assign q_bit    = (rem_t >= {1'b0, dsr_ff});

   // centre - extent/2 + quotient
   assign sum_re = {{(SW-mec_pkg::CENTRE_W){view.centre_re[mec_pkg::CENTRE_W-1]}},
                    view.centre_re}
                 - SW'({1'b0, wdt_ff[WW-1:1]}) + SW'({1'b0, qx_ff});
   assign sum_im = {{(SW-mec_pkg::CENTRE_W){view.centre_im[mec_pkg::CENTRE_W-1]}},
                    view.centre_im}
                 - SW'({1'b0, view.height[mec_pkg::HEIGHT_W-1:1]}) + SW'({1'b0, dvd_ff});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mec_pkg::F_IDLE:  if (req_valid) state_in = mec_pkg::F_MUL_W;
         mec_pkg::F_MUL_W: state_in = mec_pkg::F_DIV_W;
         mec_pkg::F_DIV_W: if (div_last) state_in = mec_pkg::F_MUL_X;
         mec_pkg::F_MUL_X: state_in = mec_pkg::F_DIV_X;
         mec_pkg::F_DIV_X: if (div_last) state_in = mec_pkg::F_MUL_Y;
         mec_pkg::F_MUL_Y: state_in = mec_pkg::F_DIV_Y;
         mec_pkg::F_DIV_Y: if (div_last) state_in = mec_pkg::F_PUSH;
         mec_pkg::F_PUSH:  if (!full) state_in = mec_pkg::F_IDLE;
         default: state_in = mec_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == mec_pkg::F_IDLE);
      push      = (state_ff == mec_pkg::F_PUSH);
      push_data.re = mec_pkg::sat_z({{(mec_pkg::SAT_W-SW){sum_re[SW-1]}}, sum_re});
      push_data.im = mec_pkg::sat_z({{(mec_pkg::SAT_W-SW){sum_im[SW-1]}}, sum_im});
      px_in  = px_ff;
      py_in  = py_ff;
      dvd_in = dvd_ff;
      qx_in  = qx_ff;
      wdt_in = wdt_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         mec_pkg::F_IDLE: begin
            px_in = req_pixel_x;
            py_in = req_pixel_y;
         end
         mec_pkg::F_MUL_W: begin
            dvd_in = DIVW'(view.height) * DIVW'(rw_eff);
            dsr_in = rh_eff;
            rem_in = '0;
            cnt_in = '0;
         end
         mec_pkg::F_MUL_X: begin
            wdt_in = dvd_ff[WW-1:0];
            dvd_in = DIVW'(dvd_ff[WW-1:0]) * DIVW'(px_ff);
            dsr_in = rw_eff;
            rem_in = '0;
            cnt_in = '0;
         end
         mec_pkg::F_MUL_Y: begin
            qx_in  = dvd_ff;
            dvd_in = DIVW'(view.height) * DIVW'(py_ff);
            dsr_in = rh_eff;
            rem_in = '0;
            cnt_in = '0;
         end
         mec_pkg::F_DIV_W, mec_pkg::F_DIV_X, mec_pkg::F_DIV_Y: begin
            // restoring division, one quotient bit per cycle
            rem_in = q_bit ? (rem_t - {1'b0, dsr_ff}) : rem_t;
            dvd_in = {dvd_ff[DIVW-2:0], q_bit};
            cnt_in = cnt_ff + CW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mec_pkg::F_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      px_ff  <= px_in;
      py_ff  <= py_in;
      dvd_ff <= dvd_in;
      qx_ff  <= qx_in;
      wdt_ff <= wdt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

// ===== sv/mec_back.sv =====
// Back end: escape-time iteration and result register.
`default_nettype none
module mec_back #(
   parameter int FRAC_BITS = mec_pkg::FRAC_BITS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            empty,
   input  wire mec_pkg::point_type        pop_data,
   output logic                           pop,
   input  wire [mec_pkg::COUNT_W-1:0]     max_iter,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [mec_pkg::COUNT_W-1:0]    rsp_escape_count,
   output logic                           rsp_hit_limit
);
   localparam int Z   = mec_pkg::ZBITS;
   localparam int CW  = mec_pkg::COUNT_W;
   localparam int THR_EXP = 2 * FRAC_BITS + 4;
   localparam bit THR_OK  = (THR_EXP <= 63);
   localparam logic [63:0] THR = THR_OK ? (64'd1 << (THR_OK ? THR_EXP : 0)) : 64'd0;

   mec_pkg::back_state_type state_ff, state_in;
   logic signed [Z-1:0]  cr_ff, cr_in, ci_ff, ci_in, zr_ff, zr_in, zi_ff, zi_in;
   logic signed [63:0]   rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [CW-1:0]        cnt_ff, cnt_in, out_cnt_ff, out_cnt_in;
   logic                 out_hit_ff, out_hit_in, out_vld_ff, out_vld_in;
   logic                 at_limit, escaped, out_free;
   logic [63:0]          mag;
   logic signed [63:0]   diff, nr_sh, ni_sh;

   assign at_limit = (cnt_ff == max_iter);
   assign mag      = 64'(rr_ff) + 64'(ii_ff);
   assign escaped  = THR_OK && (mag >= THR);
   assign out_free = !out_vld_ff || rsp_ready;
   assign diff     = rr_ff - ii_ff;
   assign nr_sh    = diff >>> FRAC_BITS;
   assign ni_sh    = ri_ff >>> (FRAC_BITS - 1);

   assign rsp_valid        = out_vld_ff;
   assign rsp_escape_count = out_cnt_ff;
   assign rsp_hit_limit    = out_hit_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mec_pkg::B_IDLE:  if (!empty) state_in = mec_pkg::B_MUL;
         mec_pkg::B_MUL:   state_in = mec_pkg::B_EVAL;
         mec_pkg::B_EVAL:  state_in = (at_limit || escaped) ? mec_pkg::B_DONE
                                                            : mec_pkg::B_MUL;
         mec_pkg::B_DONE:  if (out_free) state_in = mec_pkg::B_IDLE;
         default: state_in = mec_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop        = (state_ff == mec_pkg::B_IDLE) && !empty;
      cr_in      = cr_ff;
      ci_in      = ci_ff;
      zr_in      = zr_ff;
      zi_in      = zi_ff;
      rr_in      = rr_ff;
      ii_in      = ii_ff;
      ri_in      = ri_ff;
      cnt_in     = cnt_ff;
      out_cnt_in = out_cnt_ff;
      out_hit_in = out_hit_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      case (state_ff)
         mec_pkg::B_IDLE: begin
            cr_in  = pop_data.re;
            ci_in  = pop_data.im;
            zr_in  = pop_data.re;
            zi_in  = pop_data.im;
            cnt_in = '0;
         end
         mec_pkg::B_MUL: begin
            rr_in = 64'(zr_ff) * 64'(zr_ff);
            ii_in = 64'(zi_ff) * 64'(zi_ff);
            ri_in = 64'(zr_ff) * 64'(zi_ff);
         end
         mec_pkg::B_EVAL: begin
            if (!at_limit && !escaped) begin
               zr_in  = mec_pkg::sat_z(mec_pkg::SAT_W'(nr_sh) + mec_pkg::SAT_W'(cr_ff));
               zi_in  = mec_pkg::sat_z(mec_pkg::SAT_W'(ni_sh) + mec_pkg::SAT_W'(ci_ff));
               cnt_in = cnt_ff + CW'(1);
            end
         end
         mec_pkg::B_DONE: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_cnt_in = cnt_ff;
               out_hit_in = at_limit;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mec_pkg::B_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff      <= cr_in;
      ci_ff      <= ci_in;
      zr_ff      <= zr_in;
      zi_ff      <= zi_in;
      rr_ff      <= rr_in;
      ii_ff      <= ii_in;
      ri_ff      <= ri_in;
      cnt_ff     <= cnt_in;
      out_cnt_ff <= out_cnt_in;
      out_hit_ff <= out_hit_in;
   end
endmodule
`default_nettype wire
